### rtl/sfr_pkg.sv
// Shared types, constants and the CRC-16/XMODEM byte update for the
// silence-framed receiver. No dependencies.
package sfr_pkg;

    localparam int MAX_FRAME_DEF = 2048;
    localparam int MIN_FRAME_DEF = 4;

    localparam logic [7:0]  ADDR_RST     = 8'd10;
    localparam logic [15:0] SIL_TICK_RST = 16'd50;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam int          SIL_W        = 17;
    localparam logic [SIL_W-1:0] SIL_MAX = '1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIL_TICK = 1'd1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [2:0] V_ACCEPTED  = 3'd0;
    localparam logic [2:0] V_WRONG_ADR = 3'd1;
    localparam logic [2:0] V_BAD_CRC   = 3'd2;
    localparam logic [2:0] V_OVERFLOW  = 3'd3;
    localparam logic [2:0] V_TOO_SHORT = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [10:0] position;
        logic [2:0]  verdict;
        logic [11:0] frame_length;
        logic        broadcast;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_core_res;

    // MSB-first, init 0, no reflection, no final xor
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/sfr_core.sv
// Frame state and per-request result logic of the silence-framed receiver.
// Depends on sfr_pkg.
module sfr_core #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF,
    parameter int MIN_FRAME = sfr_pkg::MIN_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sfr_pkg::t_in_item i_item,
    input  logic [7:0]        i_dev_addr,
    input  logic [15:0]       i_sil_ticks,
    output sfr_pkg::t_core_res o_res
);
    import sfr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [SIL_W-1:0] r_sil,     n_sil;
    logic             r_run,     n_run;
    logic [CW-1:0]    r_cnt,     n_cnt;
    logic [7:0]       r_first,   n_first;
    logic [7:0]       r_older,   n_older;
    logic [7:0]       r_newer,   n_newer;
    logic [15:0]      r_crc,     n_crc;
    logic             r_ovf,     n_ovf;

    logic [SIL_W-1:0] sil_inc;
    logic             full;
    logic             bcast;

    always_comb begin
        n_sil   = r_sil;
        n_run   = r_run;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_older = r_older;
        n_newer = r_newer;
        n_crc   = r_crc;
        n_ovf   = r_ovf;
        o_res   = '0;
        sil_inc = (r_sil == SIL_MAX) ? r_sil : r_sil + 1'b1;
        full    = (r_cnt >= CW'(MAX_FRAME));
        bcast   = (r_first == 8'd0);

        if (i_item.opcode == OP_BYTE) begin
            if (r_cnt == '0) begin
                n_run = 1'b1;
            end
            n_sil = '0;
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                if (r_cnt == '0) begin
                    n_first = i_item.rx_byte;
                end
                // the last two bytes stay out of the CRC until displaced
                if (r_cnt >= CW'(2)) begin
                    n_crc = crc16_byte(r_crc, r_older);
                end
                n_older = r_newer;
                n_newer = i_item.rx_byte;
                n_cnt   = r_cnt + 1'b1;
                o_res.valid          = 1'b1;
                o_res.item.kind      = KIND_BYTE;
                o_res.item.data_byte = i_item.rx_byte;
                o_res.item.position  = 11'(r_cnt);
            end
        end else if (r_run) begin
            if (sil_inc <= {1'b0, i_sil_ticks}) begin
                n_sil = sil_inc;
            end else begin
                o_res.valid             = 1'b1;
                o_res.item.kind         = KIND_VERDICT;
                o_res.item.frame_length = 12'(r_cnt);
                o_res.item.broadcast    = bcast;
                if (r_ovf) begin
                    o_res.item.verdict = V_OVERFLOW;
                end else if (32'(r_cnt) < 32'(MIN_FRAME)) begin
                    o_res.item.verdict = V_TOO_SHORT;
                end else if (r_first != i_dev_addr && !bcast) begin
                    o_res.item.verdict = V_WRONG_ADR;
                end else if ({r_older, r_newer} != r_crc) begin
                    o_res.item.verdict = V_BAD_CRC;
                end else begin
                    o_res.item.verdict = V_ACCEPTED;
                end
                n_sil   = '0;
                n_run   = 1'b0;
                n_cnt   = '0;
                n_first = '0;
                n_older = '0;
                n_newer = '0;
                n_crc   = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sil   <= '0;
            r_run   <= 1'b0;
            r_cnt   <= '0;
            r_first <= '0;
            r_older <= '0;
            r_newer <= '0;
            r_crc   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_step) begin
            r_sil   <= n_sil;
            r_run   <= n_run;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_older <= n_older;
            r_newer <= n_newer;
            r_crc   <= n_crc;
            r_ovf   <= n_ovf;
        end
    end

endmodule

### rtl/silence_framed_receiver_crc16.sv
// Top level of the silence-framed receiver with CRC-16/XMODEM check.
// Depends on sfr_pkg and sfr_core.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  in       | i_in_valid / o_in_stall   | i_in_data  (byte or tick)
//  out      | o_out_valid / i_out_stall | o_out_data (byte or verdict)
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled; a taken
// request passes the input register, then the result register.
// The CRC byte update is a single unrolled XOR network in the core stage.
// A stalled output holds the input register; o_in_stall rises only then.
// Synchronous active-low reset empties both registers and clears the frame.
module silence_framed_receiver_crc16 #(
    parameter int MAX_FRAME = sfr_pkg::MAX_FRAME_DEF,
    parameter int MIN_FRAME = sfr_pkg::MIN_FRAME_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sfr_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sfr_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import sfr_pkg::*;

    logic        r_in_valid, n_in_valid;
    t_in_item    r_in;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out;
    logic [7:0]  r_dev_addr;
    logic [15:0] r_sil_ticks;

    logic        step;
    logic        in_take;
    t_core_res   core_res;

    assign step       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = core_res.valid;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dev_addr  <= ADDR_RST;
            r_sil_ticks <= SIL_TICK_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DEV_ADDR: r_dev_addr  <= i_cfg_data[7:0];
                    CFG_SIL_TICK: r_sil_ticks <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (step) begin
            r_out <= core_res.item;
        end
    end

    sfr_core #(
        .MAX_FRAME (MAX_FRAME),
        .MIN_FRAME (MIN_FRAME)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_in),
        .i_dev_addr  (r_dev_addr),
        .i_sil_ticks (r_sil_ticks),
        .o_res       (core_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("registers not empty after reset");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |-> !o_in_stall)
        else $error("input stalled with free result register");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_VERDICT |->
            o_out_data.verdict <= V_TOO_SHORT)
        else $error("verdict code out of range");

    a_byte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_BYTE |->
            o_out_data.verdict == V_ACCEPTED && o_out_data.frame_length == '0
            && !o_out_data.broadcast)
        else $error("forwarded byte carries verdict fields");
`endif

endmodule

### dv/sfr_frame_checker.sv
`timescale 1ns / 100ps
// CRC helper package and the result checker for the silence-framed receiver.
// The checker mirrors the receiver, keeps the expected results in order and
// compares every accepted result. Depends on sfr_pkg.
package sfr_tb_pkg;

    // bit-serial form: each data bit, MSB first, is fed in at the top
    function automatic logic [15:0] xmodem_update(input logic [15:0] crc,
                                                  input logic [7:0]  b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ sfr_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

module sfr_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  sfr_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  sfr_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_live_items,
    output int                             o_bytes_seen,
    output int                             o_frames_seen,
    output logic [4:0]                     o_verdicts_seen
);
    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    int         fail_count    = 0;
    int         pending_q     = 0;
    int         live_items    = 0;
    int         bytes_seen    = 0;
    int         frames_seen   = 0;
    logic [4:0] verdicts_seen = '0;

    // mirrored registers and frame state
    logic [7:0]       own_addr;
    logic [15:0]      sil_limit;
    logic [SIL_W-1:0] sil_cnt;
    logic             tmr_on;
    logic [11:0]      frm_len;
    logic [7:0]       lead_byte;
    logic [7:0]       tail_old;
    logic [7:0]       tail_new;
    logic [15:0]      crc_acc;
    logic             ovf;

    t_out_item expected_results[$];

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_q;
    assign o_live_items    = live_items;
    assign o_bytes_seen    = bytes_seen;
    assign o_frames_seen   = frames_seen;
    assign o_verdicts_seen = verdicts_seen;

    function automatic string describe(input t_out_item r);
        return $sformatf("kind=%0d byte=%02h pos=%0d verdict=%0d len=%0d bcast=%0d",
                         r.kind, r.data_byte, r.position, r.verdict, r.frame_length,
                         r.broadcast);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic clear_frame_state();
        sil_cnt   = '0;
        tmr_on    = 1'b0;
        frm_len   = '0;
        lead_byte = '0;
        tail_old  = '0;
        tail_new  = '0;
        crc_acc   = '0;
        ovf       = 1'b0;
    endtask

    // one request in, at most one expected result out
    task automatic absorb_request(input t_in_item req);
        t_out_item res;
        res = '0;
        if (req.opcode == OP_BYTE) begin
            live_items++;
            if (frm_len == 0) begin
                tmr_on = 1'b1;
            end
            sil_cnt = '0;
            if (frm_len >= MAX_FRAME_DEF) begin
                ovf = 1'b1;  // dropped, yet it still counts as line activity
            end else begin
                if (frm_len == 0) begin
                    lead_byte = req.rx_byte;
                end
                // the two newest bytes stay out of the CRC until pushed along
                if (frm_len >= 2) begin
                    crc_acc = xmodem_update(crc_acc, tail_old);
                end
                tail_old       = tail_new;
                tail_new       = req.rx_byte;
                res.kind       = KIND_BYTE;
                res.data_byte  = req.rx_byte;
                res.position   = frm_len[10:0];
                expected_results.push_back(res);
                frm_len++;
            end
        end else if (tmr_on) begin
            live_items++;
            if (sil_cnt != SIL_MAX) begin
                sil_cnt++;
            end
            if (sil_cnt > {1'b0, sil_limit}) begin
                res.kind = KIND_VERDICT;
                if (ovf) begin
                    res.verdict = V_OVERFLOW;
                end else if (frm_len < MIN_FRAME_DEF) begin
                    res.verdict = V_TOO_SHORT;
                end else if (lead_byte != own_addr && lead_byte != 8'h00) begin
                    res.verdict = V_WRONG_ADR;
                end else if ({tail_old, tail_new} != crc_acc) begin
                    res.verdict = V_BAD_CRC;
                end else begin
                    res.verdict = V_ACCEPTED;
                end
                res.frame_length = frm_len;
                res.broadcast    = (lead_byte == 8'h00);
                expected_results.push_back(res);
                clear_frame_state();
            end
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (got.kind == KIND_BYTE) begin
            bytes_seen++;
        end else begin
            frames_seen++;
            if (got.verdict <= V_TOO_SHORT) begin
                verdicts_seen[got.verdict] = 1'b1;
            end
        end
        if (expected_results.size() == 0) begin
            note_failure($sformatf("result with nothing expected: %s", describe(got)));
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.position !== want.position || got.verdict !== want.verdict ||
            got.frame_length !== want.frame_length || got.broadcast !== want.broadcast) begin
            note_failure($sformatf("expected %s, got %s", describe(want), describe(got)));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr  = ADDR_RST;
            sil_limit = SIL_TICK_RST;
            clear_frame_state();
            expected_results.delete();
        end else begin
            // a result never leaves in the cycle its request enters
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out_data);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEV_ADDR: own_addr  = i_cfg_data[7:0];
                    CFG_SIL_TICK: sil_limit = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_request(i_in_data);
            end
        end
        pending_q = expected_results.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Top of the silence-framed receiver testbench: clock, reset, request and
// stall generation, register writes and the final verdict.
// Depends on sfr_pkg, sfr_tb_pkg, sfr_frame_checker and the receiver RTL.
module tb;
    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int LIVE_TARGET = 800;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int         fail_count;
    int         pending;
    int         live_items;
    int         bytes_seen;
    int         frames_seen;
    logic [4:0] verdicts_seen;

    // stimulus-side copy of what was last written
    logic [7:0]  cur_addr  = ADDR_RST;
    logic [15:0] cur_ticks = SIL_TICK_RST;
    bit          gaps_on   = 1'b1;
    int          n_configs = 0;

    int span_left   = 0;
    int stall_pick;
    int idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    silence_framed_receiver_crc16 dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sfr_frame_checker frame_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_live_items    (live_items),
        .o_bytes_seen    (bytes_seen),
        .o_frames_seen   (frames_seen),
        .o_verdicts_seen (verdicts_seen)
    );

    // output back-pressure: short bursts mostly, now and then a long stall
    // or a long clear stretch
    always @(negedge clk) begin
        if (span_left > 0) begin
            span_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 55) begin
                out_stall = 1'b0;
                span_left = $urandom_range(0, 5);
            end else if (stall_pick < 88) begin
                out_stall = 1'b1;
                span_left = $urandom_range(0, 2);
            end else if (stall_pick < 94) begin
                out_stall = 1'b1;
                span_left = $urandom_range(8, 40);
            end else begin
                out_stall = 1'b0;
                span_left = $urandom_range(40, 200);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic push_request(input logic op, input logic [7:0] b);
        in_data.opcode  = op;
        in_data.rx_byte = b;
        in_valid        = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 99) < 30) begin
            in_valid = 1'b0;
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(8, 30)) @(negedge clk);
            end else begin
                repeat ($urandom_range(1, 3)) @(negedge clk);
            end
        end
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++) begin
            push_request(OP_TICK, 8'($urandom));
        end
    endtask

    // hold off until every expected result is out, then let the pipe empty
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_DEV_ADDR) begin
            cur_addr = val[7:0];
        end else begin
            cur_ticks = val;
        end
    endtask

    task automatic reconfigure(input logic [7:0] addr, input logic [15:0] ticks);
        logic [7:0] junk;
        junk = 8'($urandom);  // upper bits of the address write are don't-care
        settle();
        write_reg(CFG_DEV_ADDR, {junk, addr});
        write_reg(CFG_SIL_TICK, ticks);
        n_configs++;
    endtask

    // frame = lead byte, payload, CRC big-endian over all but the last two,
    // closed by one tick more than the silence limit
    task automatic send_frame(input int len, input logic [7:0] lead, input bit good_crc,
                              input bit mid_ticks);
        logic [15:0] crc;
        logic [7:0]  b;
        int          hush;
        crc = '0;
        for (int k = 0; k < len; k++) begin
            if (k == 0) begin
                b = lead;
            end else if (k <= len - 3) begin
                b = 8'($urandom);
            end else if (k == len - 2) begin
                b = crc[15:8];
            end else begin
                b = crc[7:0];
                if (!good_crc) begin
                    b = b ^ 8'($urandom_range(1, 255));
                end
            end
            if (k <= len - 3) begin
                crc = xmodem_update(crc, b);
            end
            push_request(OP_BYTE, b);
            // quiet spells inside the frame, up to exactly the limit
            if (mid_ticks && cur_ticks != 0 && k != len - 1 && $urandom_range(0, 6) == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    hush = int'(cur_ticks);
                end else begin
                    hush = $urandom_range(1, (cur_ticks > 3) ? 3 : int'(cur_ticks));
                end
                send_ticks(hush);
            end
        end
        send_ticks(int'(cur_ticks) + 1);
    endtask

    task automatic random_frame();
        int         len;
        int         pick;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            len = $urandom_range(1, 3);
        end else if (pick < 85) begin
            len = $urandom_range(4, 12);
        end else begin
            len = $urandom_range(13, 40);
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            lead = cur_addr;
        end else if (pick < 80) begin
            lead = 8'h00;
        end else begin
            lead = 8'($urandom);
        end
        send_frame(len, lead, $urandom_range(0, 4) != 0, 1'b1);
    endtask

    initial begin
        int         frame_no;
        int         pick;
        logic [7:0] addr;
        logic [15:0] ticks;
        frame_no = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset register values: address 10, 50 quiet ticks allowed
        send_frame(6, ADDR_RST, 1'b1, 1'b1);

        // directed: extremes and each verdict but overflow
        reconfigure(8'hFF, 16'd0);
        push_request(OP_TICK, 8'h00);              // tick on an idle line
        send_frame(4, 8'h00, 1'b1, 1'b0);          // broadcast, accepted
        send_frame(4, 8'hFF, 1'b1, 1'b0);          // own address, accepted
        send_frame(4, 8'hFF, 1'b0, 1'b0);          // bad CRC
        send_frame(3, 8'hFF, 1'b1, 1'b0);          // too short
        send_frame(5, 8'h0A, 1'b1, 1'b0);          // someone else's address

        while (live_items < LIVE_TARGET) begin
            if (frame_no % 8 == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    addr = 8'd1;
                end else if (pick < 50) begin
                    addr = 8'd255;
                end else begin
                    addr = 8'($urandom_range(1, 255));
                end
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    ticks = 16'd0;
                end else if (pick < 80) begin
                    ticks = 16'($urandom_range(1, 6));
                end else begin
                    ticks = 16'($urandom_range(7, 60));
                end
                reconfigure(addr, ticks);
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                // raw noise, then silence to close whatever it opened
                repeat ($urandom_range(1, 10))
                    push_request(1'($urandom_range(0, 1)), 8'($urandom));
                send_ticks(int'(cur_ticks) + 1);
            end else begin
                random_frame();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_ticks($urandom_range(1, 2));
            end
            if ($urandom_range(0, 19) == 0) begin
                settle();
            end
            frame_no++;
        end

        // buffer limit: one byte past the end
        gaps_on = 1'b1;
        reconfigure(8'($urandom_range(1, 255)), 16'd2);
        send_frame(MAX_FRAME_DEF + 1, cur_addr, 1'b1, 1'b0);

        // longest silence limit: an open frame stays open, then a short limit
        // closes it
        reconfigure(cur_addr, 16'hFFFF);
        push_request(OP_BYTE, cur_addr);
        send_ticks(20);
        reconfigure(cur_addr, 16'd3);
        send_ticks(4);

        settle();
        repeat (6) @(negedge clk);

        $display("Run covered %0d forwarded bytes and %0d frame verdicts over %0d settings,",
                 bytes_seen, frames_seen, n_configs);
        $display("frames of 1 to %0d bytes; verdict codes seen (bit per code): %b",
                 MAX_FRAME_DEF + 1, verdicts_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
